[rtl/rrr_pkg.sv]
// ----------------------------------------------------------------------------
// rrr_pkg
// shared widths, constants and types of the range residual rms block
// ----------------------------------------------------------------------------
package rrr_pkg;

	localparam int FIELD_W    = 48;
	localparam int NUM_AXES   = 3;
	localparam int IN_DATA_W  = 10 * FIELD_W;
	localparam int RANGE_LSB  = 9 * FIELD_W;
	localparam int DIFF_W     = FIELD_W + 2;
	localparam int HALF_W     = DIFF_W / 2;
	localparam int MUL_W      = 32;
	localparam int PROD_W     = 2 * MUL_W;
	localparam int NUM_W      = 2 * DIFF_W;
	localparam int ROOT_W     = DIFF_W;
	localparam int REM_W      = ROOT_W + 3;
	localparam int SUM_W      = 64;
	localparam int RES_W      = SUM_W;
	localparam int CNT_W      = 21;
	localparam int RMS_W      = 32;
	localparam int OUT_DATA_W = 56;
	localparam int SQRT_STEPS = NUM_W / 2;
	localparam int DIV_STEPS  = SUM_W;
	localparam int STEP_W     = $clog2(DIV_STEPS);
	localparam int MAX_OBS    = 1048576;

	typedef enum logic {
		MODE_SQRT,
		MODE_DIV
	} shsub_mode_t;

	typedef struct packed {
		logic        start;
		shsub_mode_t mode;
	} shsub_cmd_t;

endpackage

[rtl/rrr_shsub.sv]
// ----------------------------------------------------------------------------
// rrr_shsub
// shared shift-subtract unit: restoring square root (two bits a step) or
// restoring division (one bit a step), one step per cycle
// ----------------------------------------------------------------------------
module rrr_shsub (
	input  logic                        clk,
	input  logic                        arst_n,
	input  rrr_pkg::shsub_cmd_t         cmd,
	input  logic [rrr_pkg::NUM_W-1:0]   operand,
	input  logic [rrr_pkg::CNT_W-1:0]   divisor,
	output logic                        done,
	output logic [rrr_pkg::RES_W-1:0]   result
);

	logic                          busy_q;
	logic                          done_q;
	logic [rrr_pkg::STEP_W-1:0]    cnt_q;
	rrr_pkg::shsub_mode_t          mode_q;
	logic [rrr_pkg::NUM_W-1:0]     num_q;
	logic [rrr_pkg::REM_W-1:0]     rem_q;
	logic [rrr_pkg::RES_W-1:0]     res_q;
	logic [rrr_pkg::CNT_W-1:0]     div_q;

	logic [rrr_pkg::REM_W-1:0]     rem_sh;
	logic [rrr_pkg::REM_W-1:0]     trial;
	logic [rrr_pkg::REM_W-1:0]     rem_nx;
	logic [rrr_pkg::NUM_W-1:0]     num_nx;
	logic                          ge;

	always_comb begin
		unique case (mode_q)
			rrr_pkg::MODE_SQRT: begin
				rem_sh = {rem_q[rrr_pkg::REM_W-3:0], num_q[rrr_pkg::NUM_W-1 -: 2]};
				trial  = {res_q[rrr_pkg::REM_W-3:0], 2'b01};
				num_nx = {num_q[rrr_pkg::NUM_W-3:0], 2'b00};
			end
			rrr_pkg::MODE_DIV: begin
				rem_sh = {rem_q[rrr_pkg::REM_W-2:0], num_q[rrr_pkg::NUM_W-1]};
				trial  = rrr_pkg::REM_W'(div_q);
				num_nx = {num_q[rrr_pkg::NUM_W-2:0], 1'b0};
			end
			default: begin
				rem_sh = '0;
				trial  = '0;
				num_nx = '0;
			end
		endcase
		ge     = (rem_sh >= trial);
		rem_nx = ge ? (rem_sh - trial) : rem_sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				if (cmd.mode == rrr_pkg::MODE_SQRT) begin
					cnt_q <= rrr_pkg::STEP_W'(rrr_pkg::SQRT_STEPS - 1);
				end else begin
					cnt_q <= rrr_pkg::STEP_W'(rrr_pkg::DIV_STEPS - 1);
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			mode_q <= cmd.mode;
			num_q  <= operand;
			rem_q  <= '0;
			res_q  <= '0;
			div_q  <= divisor;
		end else if (busy_q) begin
			num_q <= num_nx;
			rem_q <= rem_nx;
			res_q <= {res_q[rrr_pkg::RES_W-2:0], ge};
		end
	end

	assign done   = done_q;
	assign result = res_q;

endmodule

[rtl/range_residual_rms.sv]
// ----------------------------------------------------------------------------
// range_residual_rms
// root mean square of laser range residuals over a set of observations
// ----------------------------------------------------------------------------
// channel  dir  transaction
// s_*      in   one observation (or empty marker), tlast closes the set
// m_*      out  rms, count and saturation flag of a closed set
//
// an item with data uses the shared 32x32 multiplier for the squared axis
// terms, the shift-subtract unit for the norm root, and the multiplier again
// for the residual square, which is then accumulated
// an item that closes a non-empty set adds a 64-step divide and a 50-step root
// in the same shift-subtract unit; s_tready is low while an item is at work
// a finished result waits in the output register; only a later close waits on it
// arst_n clears the accumulator, count and flag
// ----------------------------------------------------------------------------
module range_residual_rms (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// point_x, point_y, point_z, center_x, center_y, center_z,
	// bias_x, bias_y, bias_z, measured_range
	input  logic [rrr_pkg::IN_DATA_W-1:0]    s_tdata,
	input  logic                             s_tlast,
	// has_data
	input  logic                             s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// rms_value, obs_count, zero pad
	output logic [rrr_pkg::OUT_DATA_W-1:0]   m_tdata,
	// saturated
	output logic                             m_tuser
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_ABS,
		S_MUL,
		S_MDRAIN,
		S_NSTART,
		S_NWAIT,
		S_RESID,
		S_SQ,
		S_SQADD,
		S_FIN,
		S_DSTART,
		S_DWAIT,
		S_RSTART,
		S_RWAIT,
		S_OUT
	} state_t;

	typedef enum logic [1:0] {
		P_LL,
		P_LH,
		P_HH
	} part_t;

	localparam int PAD_W = rrr_pkg::NUM_W - rrr_pkg::SUM_W;

	state_t                          state_q;
	logic [1:0]                      axis_q;
	part_t                           part_q;
	logic [rrr_pkg::CNT_W-1:0]       count_q;
	logic [rrr_pkg::SUM_W-1:0]       sum_q;
	logic                            ovf_q;
	logic                            out_valid_q;
	logic                            pacc_s1;

	logic [rrr_pkg::DIFF_W-1:0]      diff_q [rrr_pkg::NUM_AXES];
	logic [rrr_pkg::DIFF_W-1:0]      mag_q  [rrr_pkg::NUM_AXES];
	logic [rrr_pkg::FIELD_W-1:0]     range_q;
	logic                            last_q;
	logic [rrr_pkg::PROD_W-1:0]      prod_s1;
	part_t                           ppart_s1;
	logic [rrr_pkg::NUM_W-1:0]       acc_q;
	logic [rrr_pkg::ROOT_W-1:0]      norm_q;
	logic [rrr_pkg::RMS_W-1:0]       mag32_q;
	logic                            big_q;
	logic [rrr_pkg::SUM_W-1:0]       quot_q;
	logic [rrr_pkg::RMS_W-1:0]       rms_q;
	logic [rrr_pkg::RMS_W-1:0]       out_rms_q;
	logic [rrr_pkg::CNT_W-1:0]       out_cnt_q;
	logic                            out_sat_q;

	logic                            in_acc;
	logic                            has_data;
	logic                            room;
	logic                            out_load;
	logic [rrr_pkg::DIFF_W-1:0]      diff_d [rrr_pkg::NUM_AXES];
	logic [rrr_pkg::DIFF_W-1:0]      cur_mag;
	logic [rrr_pkg::MUL_W-1:0]       mul_a;
	logic [rrr_pkg::MUL_W-1:0]       mul_b;
	logic [rrr_pkg::NUM_W-1:0]       addend;
	logic [rrr_pkg::DIFF_W-1:0]      range_ext;
	logic [rrr_pkg::DIFF_W-1:0]      resid;
	logic [rrr_pkg::SUM_W-1:0]       sq;
	logic [rrr_pkg::SUM_W:0]         sum_nx;

	rrr_pkg::shsub_cmd_t             u_cmd;
	logic [rrr_pkg::NUM_W-1:0]       u_operand;
	logic                            u_done;
	logic [rrr_pkg::RES_W-1:0]       u_res;

	assign s_tready = (state_q == S_IDLE);
	assign in_acc   = s_tvalid & s_tready;
	assign has_data = s_tuser;
	assign room     = (count_q < rrr_pkg::CNT_W'(rrr_pkg::MAX_OBS));
	assign out_load = (state_q == S_OUT) && (!out_valid_q || m_tready);

	always_comb begin
		for (int a = 0; a < rrr_pkg::NUM_AXES; a++) begin
			diff_d[a] = rrr_pkg::DIFF_W'($signed(s_tdata[a * rrr_pkg::FIELD_W +: rrr_pkg::FIELD_W]))
				- rrr_pkg::DIFF_W'($signed(s_tdata[(3 + a) * rrr_pkg::FIELD_W +: rrr_pkg::FIELD_W]))
				- rrr_pkg::DIFF_W'($signed(s_tdata[(6 + a) * rrr_pkg::FIELD_W +: rrr_pkg::FIELD_W]));
		end
	end

	// multiplier operands: axis square split into 25-bit halves, or residual square
	always_comb begin
		cur_mag = mag_q[axis_q];
		if (state_q == S_SQ) begin
			mul_a = mag32_q;
			mul_b = mag32_q;
		end else begin
			unique case (part_q)
				P_LL: begin
					mul_a = rrr_pkg::MUL_W'(cur_mag[rrr_pkg::HALF_W-1:0]);
					mul_b = rrr_pkg::MUL_W'(cur_mag[rrr_pkg::HALF_W-1:0]);
				end
				P_LH: begin
					mul_a = rrr_pkg::MUL_W'(cur_mag[rrr_pkg::HALF_W-1:0]);
					mul_b = rrr_pkg::MUL_W'(cur_mag[rrr_pkg::DIFF_W-1:rrr_pkg::HALF_W]);
				end
				P_HH: begin
					mul_a = rrr_pkg::MUL_W'(cur_mag[rrr_pkg::DIFF_W-1:rrr_pkg::HALF_W]);
					mul_b = rrr_pkg::MUL_W'(cur_mag[rrr_pkg::DIFF_W-1:rrr_pkg::HALF_W]);
				end
				default: begin
					mul_a = '0;
					mul_b = '0;
				end
			endcase
		end
	end

	// cross term counts twice, so it shifts one further
	always_comb begin
		unique case (ppart_s1)
			P_LL: addend = rrr_pkg::NUM_W'(prod_s1[2*rrr_pkg::HALF_W-1:0]);
			P_LH: addend = rrr_pkg::NUM_W'(prod_s1[2*rrr_pkg::HALF_W-1:0]) << (rrr_pkg::HALF_W + 1);
			P_HH: addend = rrr_pkg::NUM_W'(prod_s1[2*rrr_pkg::HALF_W-1:0]) << (2 * rrr_pkg::HALF_W);
			default: addend = '0;
		endcase
	end

	assign range_ext = rrr_pkg::DIFF_W'(range_q);
	assign resid     = (norm_q >= range_ext) ? (norm_q - range_ext) : (range_ext - norm_q);
	assign sq        = big_q ? '1 : prod_s1;
	assign sum_nx    = {1'b0, sum_q} + {1'b0, sq};

	always_comb begin
		u_cmd.start = (state_q == S_NSTART) || (state_q == S_DSTART) || (state_q == S_RSTART);
		u_cmd.mode  = (state_q == S_DSTART) ? rrr_pkg::MODE_DIV : rrr_pkg::MODE_SQRT;
		unique case (state_q)
			S_DSTART: u_operand = {sum_q, PAD_W'(0)};
			S_RSTART: u_operand = {PAD_W'(0), quot_q};
			default:  u_operand = acc_q;
		endcase
	end

	rrr_shsub u_shsub (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (u_cmd),
		.operand (u_operand),
		.divisor (count_q),
		.done    (u_done),
		.result  (u_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			axis_q      <= '0;
			part_q      <= P_LL;
			count_q     <= '0;
			sum_q       <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
			pacc_s1     <= 1'b0;
		end else begin
			pacc_s1 <= (state_q == S_MUL);
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (has_data && room) begin
							state_q <= S_ABS;
						end else begin
							if (has_data) begin
								ovf_q <= 1'b1;
							end
							state_q <= s_tlast ? S_FIN : S_IDLE;
						end
					end
				end
				S_ABS: begin
					axis_q  <= '0;
					part_q  <= P_LL;
					state_q <= S_MUL;
				end
				S_MUL: begin
					unique case (part_q)
						P_LL: part_q <= P_LH;
						P_LH: part_q <= P_HH;
						default: begin
							part_q <= P_LL;
							if (axis_q == 2'(rrr_pkg::NUM_AXES - 1)) begin
								state_q <= S_MDRAIN;
							end else begin
								axis_q <= axis_q + 1'b1;
							end
						end
					endcase
				end
				S_MDRAIN: state_q <= S_NSTART;
				S_NSTART: state_q <= S_NWAIT;
				S_NWAIT: begin
					if (u_done) begin
						state_q <= S_RESID;
					end
				end
				S_RESID: state_q <= S_SQ;
				S_SQ:    state_q <= S_SQADD;
				S_SQADD: begin
					if (sum_nx[rrr_pkg::SUM_W]) begin
						sum_q <= '1;
					end else begin
						sum_q <= sum_nx[rrr_pkg::SUM_W-1:0];
					end
					if (sum_nx[rrr_pkg::SUM_W] || big_q) begin
						ovf_q <= 1'b1;
					end
					count_q <= count_q + 1'b1;
					state_q <= last_q ? S_FIN : S_IDLE;
				end
				S_FIN: state_q <= (count_q == '0) ? S_OUT : S_DSTART;
				S_DSTART: state_q <= S_DWAIT;
				S_DWAIT: begin
					if (u_done) begin
						state_q <= S_RSTART;
					end
				end
				S_RSTART: state_q <= S_RWAIT;
				S_RWAIT: begin
					if (u_done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_load) begin
						sum_q   <= '0;
						count_q <= '0;
						ovf_q   <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_s1  <= mul_a * mul_b;
		ppart_s1 <= part_q;
		if (in_acc) begin
			diff_q  <= diff_d;
			range_q <= s_tdata[rrr_pkg::RANGE_LSB +: rrr_pkg::FIELD_W];
			last_q  <= s_tlast;
		end
		if (state_q == S_ABS) begin
			for (int a = 0; a < rrr_pkg::NUM_AXES; a++) begin
				mag_q[a] <= diff_q[a][rrr_pkg::DIFF_W-1] ? (~diff_q[a] + 1'b1) : diff_q[a];
			end
			acc_q <= '0;
		end else if (pacc_s1) begin
			acc_q <= acc_q + addend;
		end
		if (state_q == S_NWAIT && u_done) begin
			norm_q <= u_res[rrr_pkg::ROOT_W-1:0];
		end
		if (state_q == S_RESID) begin
			mag32_q <= resid[rrr_pkg::RMS_W-1:0];
			big_q   <= |resid[rrr_pkg::DIFF_W-1:rrr_pkg::RMS_W];
		end
		if (state_q == S_DWAIT && u_done) begin
			quot_q <= u_res;
		end
		if (state_q == S_FIN) begin
			rms_q <= '0;
		end else if (state_q == S_RWAIT && u_done) begin
			rms_q <= u_res[rrr_pkg::RMS_W-1:0];
		end
		if (out_load) begin
			out_rms_q <= rms_q;
			out_cnt_q <= count_q;
			out_sat_q <= ovf_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = rrr_pkg::OUT_DATA_W'({out_cnt_q, out_rms_q});
	assign m_tuser  = out_sat_q;

`ifndef SYNTHESIS
	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		u_done |-> (state_q == S_NWAIT || state_q == S_DWAIT || state_q == S_RWAIT))
		else $error("shift-subtract result outside a wait state");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= rrr_pkg::CNT_W'(rrr_pkg::MAX_OBS))
		else $error("observation count beyond limit");

	a_big_flags: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SQADD && big_q) |=> ovf_q)
		else $error("large residual did not set saturation");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && out_cnt_q == '0) |-> (out_rms_q == '0))
		else $error("empty set with nonzero rms");
`endif

endmodule

[test/tb_range_residual_rms.sv]
// ----------------------------------------------------------------------------
// tb_range_residual_rms
// self-checking bench for the range residual rms block
// ----------------------------------------------------------------------------
// observations are streamed in sets closed by tlast. A behavioral model
// accumulates the squared range residuals of each set and queues the
// expected rms, count and saturation flag. Every output transaction is
// checked against the oldest queued summary. Directed sets cover empty sets,
// field extremes, large residuals and accumulator overflow. Random sets
// follow, most with plausible geometry and some with raw random fields.
// Both sides idle at random.
// ----------------------------------------------------------------------------
module tb_range_residual_rms;
	timeunit 1ns;
	timeprecision 1ps;

	// point_x sits in the lowest bits, measured_range in the highest
	typedef struct packed {
		logic [rrr_pkg::FIELD_W-1:0]                        rng;
		logic [rrr_pkg::NUM_AXES-1:0][rrr_pkg::FIELD_W-1:0] bias;
		logic [rrr_pkg::NUM_AXES-1:0][rrr_pkg::FIELD_W-1:0] ctr;
		logic [rrr_pkg::NUM_AXES-1:0][rrr_pkg::FIELD_W-1:0] pt;
	} obs_fields_t;

	typedef struct {
		logic [rrr_pkg::RMS_W-1:0] rms;
		logic [rrr_pkg::CNT_W-1:0] count;
		logic                      sat;
	} set_summary_t;

	localparam logic [rrr_pkg::FIELD_W-1:0] S_MAX = {1'b0, {(rrr_pkg::FIELD_W-1){1'b1}}};
	localparam logic [rrr_pkg::FIELD_W-1:0] S_MIN = {1'b1, {(rrr_pkg::FIELD_W-1){1'b0}}};
	localparam logic [rrr_pkg::FIELD_W-1:0] U_MAX = {rrr_pkg::FIELD_W{1'b1}};

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           s_tvalid;
	logic                           s_tready;
	logic [rrr_pkg::IN_DATA_W-1:0]  s_tdata;
	logic                           s_tlast;
	logic                           s_tuser;
	logic                           m_tvalid;
	logic                           m_tready;
	logic [rrr_pkg::OUT_DATA_W-1:0] m_tdata;
	logic                           m_tuser;

	set_summary_t  pending_summaries[$];
	logic [63:0]   acc_square_sum;
	int unsigned   acc_obs_count;
	logic          acc_overflow;

	int  err_count;
	int  sets_checked;
	int  sat_sets;
	int  obs_sent;
	int  rx_hold;
	bit  tx_idle_on;
	bit  rx_idle_on;

	range_residual_rms DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #5 clk = ~clk;

	function automatic logic [63:0] floor_root(logic [127:0] v);
		logic [127:0] root;
		logic [127:0] cand;
		root = '0;
		for (int b = 63; b >= 0; b--) begin
			cand = root | (128'd1 << b);
			if (cand * cand <= v)
				root = cand;
		end
		return root[63:0];
	endfunction

	// floor of the euclidean length of point - centre - bias
	function automatic logic [63:0] offset_norm(obs_fields_t f);
		logic signed [63:0] p, c, b, d;
		logic [127:0]       m;
		logic [127:0]       sum_sq;
		sum_sq = '0;
		for (int a = 0; a < rrr_pkg::NUM_AXES; a++) begin
			p = $signed(f.pt[a]);
			c = $signed(f.ctr[a]);
			b = $signed(f.bias[a]);
			d = p - c - b;
			m = {64'd0, (d < 0) ? -d : d};
			sum_sq = sum_sq + m * m;
		end
		return floor_root(sum_sq);
	endfunction

	function automatic logic [rrr_pkg::FIELD_W-1:0] rand_raw();
		logic [63:0] v;
		v = {$urandom, $urandom};
		return v[rrr_pkg::FIELD_W-1:0];
	endfunction

	// uniform in [-2^bits, 2^bits)
	function automatic logic [rrr_pkg::FIELD_W-1:0] rand_signed(int bits);
		logic signed [63:0] v;
		v = $signed({$urandom, $urandom}) >>> (63 - bits);
		return v[rrr_pkg::FIELD_W-1:0];
	endfunction

	task automatic fold_observation(obs_fields_t f, bit has_data, bit last);
		logic [63:0] norm, rng64, mag, sq;
		logic [64:0] sum;
		set_summary_t s;
		if (has_data) begin
			if (acc_obs_count >= rrr_pkg::MAX_OBS) begin
				acc_overflow = 1'b1;
			end else begin
				norm  = offset_norm(f);
				rng64 = {16'd0, f.rng};
				mag   = (norm >= rng64) ? norm - rng64 : rng64 - norm;
				if (mag > 64'hFFFF_FFFF) begin
					sq = '1;
					acc_overflow = 1'b1;
				end else begin
					sq = mag * mag;
				end
				sum = {1'b0, acc_square_sum} + {1'b0, sq};
				if (sum[64]) begin
					acc_square_sum = '1;
					acc_overflow = 1'b1;
				end else begin
					acc_square_sum = sum[63:0];
				end
				acc_obs_count++;
			end
		end
		if (last) begin
			s.rms   = (acc_obs_count == 0) ? '0 :
				rrr_pkg::RMS_W'(floor_root({64'd0, acc_square_sum / 64'(acc_obs_count)}));
			s.count = rrr_pkg::CNT_W'(acc_obs_count);
			s.sat   = acc_overflow;
			pending_summaries.push_back(s);
			acc_square_sum = '0;
			acc_obs_count  = 0;
			acc_overflow   = 1'b0;
		end
	endtask

	task automatic send_observation(obs_fields_t f, bit has_data, bit last);
		int gap;
		gap = tx_idle_on ? $urandom_range(0, 3) : 0;
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= f;
		s_tuser  <= has_data;
		s_tlast  <= last;
		do
			@(posedge clk);
		while (!s_tready);
		fold_observation(f, has_data, last);
		if (has_data)
			obs_sent++;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do
			@(negedge clk);
		while (pending_summaries.size() != 0);
	endtask

	task automatic make_plausible(output obs_fields_t f, input int range_bits);
		logic signed [63:0] r;
		for (int a = 0; a < rrr_pkg::NUM_AXES; a++) begin
			f.ctr[a]  = rand_signed(44);
			f.bias[a] = rand_signed(40);
			f.pt[a]   = f.ctr[a] + f.bias[a] + rand_signed($urandom_range(4, 30));
		end
		r = $signed(offset_norm(f)) + $signed(64'(signed'(rand_signed(range_bits))));
		f.rng = (r < 0) ? '0 : r[rrr_pkg::FIELD_W-1:0];
	endtask

	task automatic test_empty_sets();
		obs_fields_t f;
		f = '0;
		send_observation(f, 1'b0, 1'b1);
		f.rng = U_MAX;
		send_observation(f, 1'b0, 1'b0);
		send_observation(f, 1'b0, 1'b1);
	endtask

	task automatic test_data_with_last();
		obs_fields_t f;
		make_plausible(f, 12);
		send_observation(f, 1'b1, 1'b1);
	endtask

	task automatic test_field_extremes();
		obs_fields_t f;
		f = '0;
		send_observation(f, 1'b1, 1'b1);
		f.pt   = {rrr_pkg::NUM_AXES{S_MAX}};
		f.ctr  = {rrr_pkg::NUM_AXES{S_MIN}};
		f.bias = {rrr_pkg::NUM_AXES{S_MIN}};
		send_observation(f, 1'b1, 1'b1);
		f.pt   = {rrr_pkg::NUM_AXES{S_MIN}};
		f.ctr  = {rrr_pkg::NUM_AXES{S_MAX}};
		f.bias = {rrr_pkg::NUM_AXES{S_MAX}};
		f.rng  = U_MAX;
		send_observation(f, 1'b1, 1'b1);
		f = '0;
		f.rng = U_MAX;
		send_observation(f, 1'b1, 1'b1);
		f.pt[0] = S_MAX;
		f.ctr[1] = S_MIN;
		f.bias[2] = S_MAX;
		f.rng = '0;
		send_observation(f, 1'b1, 1'b1);
	endtask

	task automatic test_large_residual();
		obs_fields_t f;
		f = '0;
		f.rng = 48'hFFFF_FFFF;
		send_observation(f, 1'b1, 1'b1);
		f.rng = 48'h1_0000_0000;
		send_observation(f, 1'b1, 1'b1);
	endtask

	task automatic test_accumulator_overflow();
		obs_fields_t f;
		f = '0;
		f.rng = 48'hFFFF_FFFF;
		send_observation(f, 1'b1, 1'b0);
		send_observation(f, 1'b1, 1'b1);
	endtask

	task automatic test_gaps_in_set();
		obs_fields_t f;
		make_plausible(f, 16);
		send_observation(f, 1'b1, 1'b0);
		send_observation(f, 1'b0, 1'b0);
		make_plausible(f, 20);
		send_observation(f, 1'b1, 1'b0);
		send_observation(f, 1'b0, 1'b1);
	endtask

	task automatic test_random_sets();
		obs_fields_t f;
		int set_len, pick, data_items, set_idx;
		bit has_data;
		data_items = 0;
		set_idx = 0;
		while (data_items < 575) begin
			set_len = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 40) :
				$urandom_range(1, 6);
			tx_idle_on = ($urandom_range(0, 3) != 0);
			rx_idle_on = ($urandom_range(0, 3) != 0);
			for (int i = 0; i < set_len; i++) begin
				pick = $urandom_range(0, 19);
				has_data = ($urandom_range(0, 9) != 0);
				if (pick == 17) begin
					f = {rand_raw(), {rrr_pkg::NUM_AXES{rand_raw()}},
						{rrr_pkg::NUM_AXES{rand_raw()}}, {rrr_pkg::NUM_AXES{rand_raw()}}};
					for (int a = 0; a < rrr_pkg::NUM_AXES; a++) begin
						f.pt[a]   = rand_raw();
						f.ctr[a]  = rand_raw();
						f.bias[a] = rand_raw();
					end
				end else begin
					make_plausible(f, (pick >= 18) ? 33 : $urandom_range(0, 24));
				end
				send_observation(f, has_data, i == set_len - 1);
				if (has_data)
					data_items++;
			end
			set_idx++;
			if (set_idx % 8 == 0)
				wait_drained();
		end
	endtask

	// result side: stall drawn per transaction
	initial begin
		m_tready = 1'b0;
		rx_hold = 0;
		forever begin
			@(negedge clk);
			if (!arst_n || rx_hold != 0) begin
				m_tready <= 1'b0;
				if (rx_hold != 0)
					rx_hold = rx_hold - 1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		set_summary_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_summaries.size() == 0) begin
				$error("unexpected result rms_value=%0d obs_count=%0d saturated=%0d",
					m_tdata[31:0], m_tdata[52:32], m_tuser);
				err_count++;
			end else begin
				want = pending_summaries.pop_front();
				if (m_tdata[31:0] !== want.rms) begin
					$error("rms_value expected %0d actual %0d", want.rms, m_tdata[31:0]);
					err_count++;
				end
				if (m_tdata[52:32] !== want.count) begin
					$error("obs_count expected %0d actual %0d", want.count, m_tdata[52:32]);
					err_count++;
				end
				if (m_tuser !== want.sat) begin
					$error("saturated expected %0d actual %0d", want.sat, m_tuser);
					err_count++;
				end
			end
			sets_checked++;
			if (m_tuser === 1'b1)
				sat_sets++;
			rx_hold = rx_idle_on ? $urandom_range(0, 3) : 0;
		end
	end

	initial begin
		#10ms;
		$display("range_residual_rms regression: fail");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		s_tuser = 1'b0;
		acc_square_sum = '0;
		acc_obs_count = 0;
		acc_overflow = 1'b0;
		err_count = 0;
		sets_checked = 0;
		sat_sets = 0;
		obs_sent = 0;
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_empty_sets();
		test_data_with_last();
		test_field_extremes();
		wait_drained();
		test_large_residual();
		test_accumulator_overflow();
		test_gaps_in_set();
		test_random_sets();

		wait_drained();
		repeat (250) @(posedge clk);
		if (pending_summaries.size() != 0) begin
			$error("%0d expected results never arrived", pending_summaries.size());
			err_count++;
		end
		$display("covered %0d sets (%0d saturated) built from %0d observations",
			sets_checked, sat_sets, obs_sent);
		$display("including empty sets, field extremes and residual and sum overflow");
		if (err_count == 0)
			$display("range_residual_rms regression: pass");
		else
			$display("range_residual_rms regression: fail");
		$finish;
	end

endmodule
